FILE: rtl/frm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_pkg: shared types and constants of the frame ring allocator
// Field widths, record store geometry, queue geometry and the words passed
// between the front, queue and back of the allocator.
// ----------------------------------------------------------------------------
package frm_pkg;

  // record ring geometry
  localparam int MAX_FRAMES = 64;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // data area limits
  localparam int AREA_MAX   = 65536;
  localparam int HDR_MAX    = 1024;

  // field widths
  localparam int AREA_W     = 17;
  localparam int HDR_W      = 11;
  localparam int LEN_W      = 16;
  localparam int FOFS_W     = 16;
  localparam int POFS_W     = 17;
  localparam int HELD_W     = 7;
  localparam int DROP_W     = 7;
  localparam int REC_W      = 2 * AREA_W;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic REG_AREA = 1'b0;
  localparam logic REG_HDR  = 1'b1;

  // result status codes
  localparam logic STAT_PLACED  = 1'b0;
  localparam logic STAT_REFUSED = 1'b1;

  // effective configuration
  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [HDR_W-1:0]  hdr;
  } cfg_t;

  // classified request word
  typedef struct packed {
    logic [AREA_W-1:0] total;
    logic [HDR_W-1:0]  hdr;
    logic              refused;
  } item_t;

  // result word
  typedef struct packed {
    logic [FOFS_W-1:0] frame_offset;
    logic [POFS_W-1:0] payload_offset;
    logic [HELD_W-1:0] frames_held;
    logic [DROP_W-1:0] frames_dropped;
    logic              status;
  } result_t;

  // advance a record slot around the ring
  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    if (s == SLOT_W'(MAX_FRAMES - 1)) begin
      n = '0;
    end else begin
      n = s + 1'b1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/frm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_front: request intake and classification
// Adds the header to the payload length and flags frames larger than the
// area, then hands the classified word to the queue.
// ----------------------------------------------------------------------------
module frm_front (
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [frm_pkg::LEN_W-1:0]  payload_length_i,
  input  frm_pkg::cfg_t              cfg_i,
  output logic                       push_o,
  output frm_pkg::item_t             item_o,
  input  logic                       q_ready_i
);
  import frm_pkg::*;

  logic [AREA_W-1:0] total;

  // frame size and refusal check
  assign total = AREA_W'(cfg_i.hdr) + AREA_W'(payload_length_i);

  assign item_o.total   = total;
  assign item_o.hdr     = cfg_i.hdr;
  assign item_o.refused = (total > cfg_i.area);

  assign s_ready_o = q_ready_i;
  assign push_o    = s_valid_i & q_ready_i;

endmodule

FILE: rtl/frm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_queue: short queue between front and back
// A small FIFO of classified words so intake and placement stall apart.
// ----------------------------------------------------------------------------
module frm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  frm_pkg::item_t item_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output frm_pkg::item_t item_o
);
  import frm_pkg::*;

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = q_mem[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: rtl/frm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frm_back: placement engine
// Walks the record ring evicting oldest frames, wraps the write point when
// the tail is short, places the frame (or refuses an oversized one) and registers the result word.
// ----------------------------------------------------------------------------
module frm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [frm_pkg::AREA_W-1:0] area_i,
  input  logic                       clear_i,
  input  logic                       q_valid_i,
  input  frm_pkg::item_t             q_item_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output frm_pkg::result_t           out_o
);
  import frm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]        st_q, st_d;
  logic [AREA_W-1:0] os_q, os_d;
  logic [AREA_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;
  logic [SLOT_W-1:0] nslot_q, nslot_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  item_t             cur_q, cur_d;
  logic              ov_q, ov_d;
  result_t           res_q, res_d;

  logic [REC_W-1:0]  rec_mem [MAX_FRAMES];
  logic [REC_W-1:0]  rd_q;
  logic [SLOT_W-1:0] rd_addr;
  logic              rec_we;
  logic [AREA_W-1:0] frame_end;

  logic [AREA_W-1:0] gap;
  logic              out_free;
  logic              full;

  assign out_free  = !ov_q || out_ready_i;
  assign full      = (held_q >= CNT_W'(MAX_FRAMES));
  assign rd_addr   = next_slot(oslot_q);
  assign frame_end = wp_q + cur_q.total;

  // free room ahead of the write point
  always_comb begin
    if (held_q == '0) begin
      gap = area_i;
    end else if (wp_q > os_q) begin
      gap = area_i - wp_q;
    end else begin
      gap = os_q - wp_q;
    end
  end

  // sequencer
  always_comb begin
    st_d    = st_q;
    os_d    = os_q;
    wp_d    = wp_q;
    held_d  = held_q;
    oslot_d = oslot_q;
    nslot_d = nslot_q;
    drop_d  = drop_q;
    cur_d   = cur_q;
    ov_d    = ov_q;
    res_d   = res_q;
    q_pop_o = 1'b0;
    rec_we  = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          drop_d  = '0;
          st_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (cur_q.refused) begin
          if (out_free) begin
            ov_d                 = 1'b1;
            res_d.frame_offset   = '0;
            res_d.payload_offset = '0;
            res_d.frames_held    = HELD_W'(held_q);
            res_d.frames_dropped = '0;
            res_d.status         = STAT_REFUSED;
            st_d                 = ST_IDLE;
          end
        end else if (!full && gap >= cur_q.total) begin
          if (out_free) begin
            rec_we               = 1'b1;
            nslot_d              = next_slot(nslot_q);
            held_d               = held_q + 1'b1;
            wp_d                 = frame_end;
            if (held_q == '0) begin
              os_d = wp_q;
            end
            ov_d                 = 1'b1;
            res_d.frame_offset   = wp_q[FOFS_W-1:0];
            res_d.payload_offset = POFS_W'(wp_q) + POFS_W'(cur_q.hdr);
            res_d.frames_held    = HELD_W'(held_q);
            res_d.frames_dropped = drop_q;
            res_d.status         = STAT_PLACED;
            st_d                 = ST_IDLE;
          end
        end else if (!full && wp_q > os_q) begin
          // tail too short: wrap, wasting it
          wp_d = '0;
        end else begin
          // evict the oldest frame
          oslot_d = next_slot(oslot_q);
          held_d  = held_q - 1'b1;
          drop_d  = drop_q + 1'b1;
          if (held_q == CNT_W'(1)) begin
            os_d = '0;
            wp_d = '0;
          end else begin
            st_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        // record of the new oldest frame has arrived
        os_d = rd_q[AREA_W-1:0];
        st_d = ST_EVAL;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (clear_i) begin
      st_d    = ST_IDLE;
      os_d    = '0;
      wp_d    = '0;
      held_d  = '0;
      oslot_d = '0;
      nslot_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      os_q    <= '0;
      wp_q    <= '0;
      held_q  <= '0;
      oslot_q <= '0;
      nslot_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      os_q    <= os_d;
      wp_q    <= wp_d;
      held_q  <= held_d;
      oslot_q <= oslot_d;
      nslot_q <= nslot_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    drop_q <= drop_d;
    res_q  <= res_d;
  end

  // frame record store: end in the upper half, start in the lower half
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[nslot_q] <= {frame_end, wp_q};
    end
    rd_q <= rec_mem[rd_addr];
  end

  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  // held count never exceeds the record ring
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(MAX_FRAMES))
    else $error("held count above ring depth");

  // an empty store sits at offset zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (os_q == '0 && wp_q == '0))
    else $error("empty store with nonzero offsets");

  // write point stays inside the area
  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= area_i)
    else $error("write point beyond area");

  // a record fetch is followed by evaluation unless a clear comes in between
  a_wait_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WAIT && !clear_i) |=> (st_q == ST_EVAL))
    else $error("record fetch not followed by evaluation");

endmodule

FILE: rtl/frame_ring_allocator_drop_oldest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_ring_allocator_drop_oldest: circular frame allocator, drop oldest
// Places frames of header plus payload contiguously in a circular byte area,
// evicting the oldest frames to make room.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word per frame: its payload length.
//   m_axis returns one result word per request: frame and payload offsets,
//   frames held before the insert, frames dropped; tuser is the status
//   (1 = frame larger than the area, nothing changed).
//   APB registers: 0x0 area_size, 0x4 header_bytes. Writing area_size
//   empties the store. Write registers only while the block is idle.
// Flow:
//   An accepted word is written into the queue, then taken into the placement
//   engine, which holds one word at a time, and its result is registered.
//   The engine spends an evaluation step on every evicted frame, followed by a
//   record fetch from the record memory (none for the eviction that empties
//   the store), and an evaluation step when the write point wraps.
//   A 2-word queue sits between intake and placement, so requests keep
//   being accepted while a result waits or frames are evicted; once the
//   queue is full, s_axis_tready drops until the placement engine takes
//   the next word, which waits on m_axis_tready when a result is pending.
// Reset: the store is empty, area_size is 65536 and header_bytes is 32.
// ----------------------------------------------------------------------------
module frame_ring_allocator_drop_oldest (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] payload_length
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] frame_offset, [32:16] payload_offset,
                                      // [39:33] frames_held, [46:40] frames_dropped,
                                      // [47] zero
  output logic        m_axis_tuser,   // [0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import frm_pkg::*;

  logic [AREA_W-1:0] area_q, area_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic              wr_en;
  logic              clear;
  cfg_t              cfg;
  logic              push, q_ready, q_valid, q_pop;
  item_t             push_item, q_item;
  result_t           res;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign clear  = wr_en && (paddr[2] == REG_AREA);

  always_comb begin
    area_d = area_q;
    hdr_d  = hdr_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_AREA: area_d = pwdata[AREA_W-1:0];
        REG_HDR:  hdr_d  = pwdata[HDR_W-1:0];
        default:  area_d = area_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= AREA_W'(AREA_MAX);
      hdr_q  <= HDR_W'(32);
    end else begin
      area_q <= area_d;
      hdr_q  <= hdr_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_AREA: prdata = 32'(area_q);
      REG_HDR:  prdata = 32'(hdr_q);
      default:  prdata = '0;
    endcase
  end

  // effective register values
  always_comb begin
    if (area_q == '0) begin
      cfg.area = AREA_W'(1);
    end else if (area_q > AREA_W'(AREA_MAX)) begin
      cfg.area = AREA_W'(AREA_MAX);
    end else begin
      cfg.area = area_q;
    end
    if (hdr_q == '0) begin
      cfg.hdr = HDR_W'(1);
    end else if (hdr_q > HDR_W'(HDR_MAX)) begin
      cfg.hdr = HDR_W'(HDR_MAX);
    end else begin
      cfg.hdr = hdr_q;
    end
  end

  frm_front u_front (
    .s_valid_i        (s_axis_tvalid),
    .s_ready_o        (s_axis_tready),
    .payload_length_i (s_axis_tdata),
    .cfg_i            (cfg),
    .push_o           (push),
    .item_o           (push_item),
    .q_ready_i        (q_ready)
  );

  frm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  frm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .area_i      (cfg.area),
    .clear_i     (clear),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // result packing
  assign m_axis_tdata = {1'b0, res.frames_dropped, res.frames_held,
                         res.payload_offset, res.frame_offset};
  assign m_axis_tuser = res.status;

endmodule

FILE: tb/frame_ring_allocator_drop_oldest_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_ring_allocator_drop_oldest_test: self-checking bench of the allocator
// A short directed table covers register extremes, refused frames, wrapping
// and eviction down to an empty store. Random phases follow, each under a
// fresh area and header setting. Every request word goes through a local
// placement model, and each result word is compared with the oldest
// expectation, field by field.
// ----------------------------------------------------------------------------
module frame_ring_allocator_drop_oldest_test;
  import frm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 75;

  typedef enum logic [1:0] {ROW_WORD, ROW_AREA, ROW_HDR} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int unsigned value;
    bit          pinned;
    result_t     want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [15:0] payload_length
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;    // [15:0] frame_offset, [32:16] payload_offset,
                                // [39:33] frames_held, [46:40] frames_dropped, [47] zero
  logic        m_axis_tuser;    // [0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // expectation pinned by the directed table, travels with the word
  logic        pin_valid;
  result_t     pin_result;

  // allocator model state
  logic [AREA_W-1:0] area_reg;
  logic [HDR_W-1:0]  hdr_reg;
  logic [AREA_W-1:0] oldest_ofs;
  logic [AREA_W-1:0] wr_ptr;
  logic [CNT_W-1:0]  held_cnt;
  logic [SLOT_W-1:0] old_slot;
  logic [SLOT_W-1:0] new_slot;
  logic [AREA_W-1:0] rec_start [MAX_FRAMES];

  result_t placements_q[$];
  row_t    plan[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      stall_left = 0;

  frame_ring_allocator_drop_oldest DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  // out-of-range register values are clamped
  function automatic int unsigned eff_area();
    if (area_reg == 0) return 1;
    if (area_reg > AREA_MAX) return AREA_MAX;
    return area_reg;
  endfunction

  function automatic int unsigned eff_hdr();
    if (hdr_reg == 0) return 1;
    if (hdr_reg > HDR_MAX) return HDR_MAX;
    return hdr_reg;
  endfunction

  function automatic void clear_store();
    oldest_ofs = '0;
    wr_ptr     = '0;
    held_cnt   = '0;
    old_slot   = '0;
    new_slot   = '0;
  endfunction

  // drop the oldest frame; an emptied store restarts at offset zero
  function automatic void evict_oldest();
    old_slot = old_slot + 1'b1;
    held_cnt = held_cnt - 1'b1;
    if (held_cnt == 0) begin
      oldest_ofs = '0;
      wr_ptr     = '0;
    end else begin
      oldest_ofs = rec_start[old_slot];
    end
  endfunction

  function automatic result_t place_frame(input logic [LEN_W-1:0] len);
    int unsigned area, hdr, total, gap, dropped;
    result_t r;
    area    = eff_area();
    hdr     = eff_hdr();
    total   = hdr + len;
    dropped = 0;
    r       = '0;
    // frame can never fit: refused, nothing changes
    if (total > area) begin
      r.frames_held = HELD_W'(held_cnt);
      r.status      = STAT_REFUSED;
      return r;
    end
    if (held_cnt == 0) begin
      oldest_ofs = '0;
      wr_ptr     = '0;
    end
    // record ring full
    while (held_cnt >= MAX_FRAMES) begin
      evict_oldest();
      dropped++;
    end
    // wrap past a short tail, then evict until the gap is big enough
    forever begin
      if (held_cnt == 0) gap = area;
      else if (wr_ptr > oldest_ofs) gap = area - wr_ptr;
      else gap = oldest_ofs - wr_ptr;
      if (gap >= total) break;
      if (wr_ptr > oldest_ofs) begin
        wr_ptr = '0;
      end else begin
        evict_oldest();
        dropped++;
      end
    end
    r.frame_offset   = wr_ptr[FOFS_W-1:0];
    r.payload_offset = POFS_W'(wr_ptr + hdr);
    r.frames_held    = HELD_W'(held_cnt);
    r.frames_dropped = DROP_W'(dropped);
    r.status         = STAT_PLACED;
    if (held_cnt == 0) oldest_ofs = wr_ptr;
    rec_start[new_slot] = wr_ptr;
    new_slot = new_slot + 1'b1;
    held_cnt = held_cnt + 1'b1;
    wr_ptr   = AREA_W'(wr_ptr + total);
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus

  task automatic add_row(input row_kind_e kind, input int unsigned value,
                         input bit pinned, input result_t want);
    row_t row;
    row.kind   = kind;
    row.value  = value;
    row.pinned = pinned;
    row.want   = want;
    plan.push_back(row);
  endtask

  // present one request word, with an occasional idle burst ahead of it
  task automatic send_word(input logic [15:0] len, input bit pinned,
                           input result_t want);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= len;
    pin_valid     <= pinned;
    pin_result    <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and wait until every result word is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (placements_q.size() != 0);
    @(posedge clk_i);
  endtask

  // APB write: setup then access, model follows the register
  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_AREA) begin
      area_reg = value[AREA_W-1:0];
      clear_store();
    end else begin
      hdr_reg = value[HDR_W-1:0];
    end
  endtask

  // payload length scaled to the current area; shift sets the frame size
  function automatic logic [15:0] pick_length(input int shift);
    int unsigned room, a, h, r;
    a = eff_area();
    h = eff_hdr();
    room = (a > h) ? a - h : 0;
    if (room > 65535) room = 65535;
    r = $urandom_range(99);
    if (r < 10) return 16'($urandom);
    if (r < 15) return '0;
    if (r < 20) return 16'(room);
    return 16'($urandom_range(room >> shift, 0));
  endfunction

  // --------------------------------------------------------- result sink

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(18, 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ------------------------------------------------------------- monitor

  always @(posedge clk_i) begin : monitor
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      // result words first, so a same-edge request cannot hide a stray one
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (placements_q.size() == 0) begin
          if (mismatches < 10)
            $display("result word with nothing expected: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = placements_q.pop_front();
          check_field("frame_offset", want.frame_offset, m_axis_tdata[15:0]);
          check_field("payload_offset", want.payload_offset, m_axis_tdata[32:16]);
          check_field("frames_held", want.frames_held, m_axis_tdata[39:33]);
          check_field("frames_dropped", want.frames_dropped, m_axis_tdata[46:40]);
          check_field("tdata pad", 0, m_axis_tdata[47]);
          check_field("status", want.status, m_axis_tuser);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        want = place_frame(s_axis_tdata);
        if (pin_valid) want = pin_result;
        placements_q.push_back(want);
      end
      // watchdog: count stuck cycles only while work is pending
      if (moved || (placements_q.size() == 0 && !s_axis_tvalid)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main

  initial begin : main
    int          phase, n, shift;
    int unsigned area_val, hdr_val;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    pin_valid     = 1'b0;
    pin_result    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    area_reg      = AREA_W'(AREA_MAX);
    hdr_reg       = HDR_W'(32);
    clear_store();

    // defaults after reset: area 65536, header 32
    add_row(ROW_WORD, 0,     1, {16'd0, 17'd32, 7'd0, 7'd0, STAT_PLACED});
    add_row(ROW_WORD, 65535, 1, {16'd0, 17'd0,  7'd1, 7'd0, STAT_REFUSED});
    // exactly the whole area: wrap, evict, store empties
    add_row(ROW_WORD, 65504, 1, {16'd0, 17'd32, 7'd0, 7'd1, STAT_PLACED});
    add_row(ROW_WORD, 0,     1, {16'd0, 17'd32, 7'd0, 7'd1, STAT_PLACED});
    // zero registers act as one
    add_row(ROW_HDR,  0,     0, '0);
    add_row(ROW_AREA, 0,     0, '0);
    add_row(ROW_WORD, 0,     1, {16'd0, 17'd1,  7'd0, 7'd0, STAT_PLACED});
    add_row(ROW_WORD, 1,     1, {16'd0, 17'd0,  7'd1, 7'd0, STAT_REFUSED});
    add_row(ROW_WORD, 0,     1, {16'd0, 17'd1,  7'd0, 7'd1, STAT_PLACED});
    // oversized registers clamp to their maximum
    add_row(ROW_AREA, 131071, 0, '0);
    add_row(ROW_HDR,  2047,   0, '0);
    add_row(ROW_WORD, 64512,  1, {16'd0, 17'd1024, 7'd0, 7'd0, STAT_PLACED});
    add_row(ROW_WORD, 64513,  1, {16'd0, 17'd0,    7'd1, 7'd0, STAT_REFUSED});
    add_row(ROW_WORD, 65535,  1, {16'd0, 17'd0,    7'd1, 7'd0, STAT_REFUSED});
    // header alone larger than a small area
    add_row(ROW_AREA, 100,    0, '0);
    add_row(ROW_HDR,  1024,   0, '0);
    add_row(ROW_WORD, 0,      1, {16'd0, 17'd0, 7'd0, 7'd0, STAT_REFUSED});
    // small area: wasted tail, survivor-limited gap, full-area frame
    add_row(ROW_HDR,  1,      0, '0);
    add_row(ROW_WORD, 40,     0, '0);
    add_row(ROW_WORD, 40,     0, '0);
    add_row(ROW_WORD, 40,     0, '0);
    add_row(ROW_WORD, 30,     0, '0);
    add_row(ROW_WORD, 99,     0, '0);
    add_row(ROW_WORD, 16'hAAAA, 0, '0);
    add_row(ROW_WORD, 16'h5555, 0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WORD: begin
          send_word(16'(plan[i].value), plan[i].pinned, plan[i].want);
        end
        ROW_AREA: begin
          wait_idle();
          reg_write(REG_AREA, plan[i].value);
        end
        default: begin
          wait_idle();
          reg_write(REG_HDR, plan[i].value);
        end
      endcase
    end

    // random phases, each under its own register setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase % 3 == 1) begin
        // many tiny frames in a big area: the record ring fills up
        area_val = AREA_MAX;
        hdr_val  = $urandom_range(64, 1);
        shift    = 8;
      end else begin
        case ($urandom_range(4))
          0:       area_val = AREA_MAX;
          1:       area_val = $urandom_range(131071, AREA_MAX + 1);
          2:       area_val = $urandom_range(4096, 256);
          default: area_val = $urandom_range(AREA_MAX, 1);
        endcase
        case ($urandom_range(5))
          0:       hdr_val = 0;
          1:       hdr_val = 1;
          2:       hdr_val = 32;
          3:       hdr_val = $urandom_range(2047, HDR_MAX);
          4:       hdr_val = $urandom_range(HDR_MAX, 1);
          default: hdr_val = $urandom_range(64, 1);
        endcase
        shift = $urandom_range(6, 0);
      end
      reg_write(REG_AREA, area_val);
      reg_write(REG_HDR, hdr_val);
      if (phase == RANDOM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       gap_pct = 0;
          1:       gap_pct = 20;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      for (n = 0; n < PHASE_WORDS; n++)
        send_word(pick_length(shift), 1'b0, '0);
    end

    // drain, then let the pipeline settle
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/frm_pkg.sv
rtl/frm_front.sv
rtl/frm_queue.sv
rtl/frm_back.sv
rtl/frame_ring_allocator_drop_oldest.sv
tb/frame_ring_allocator_drop_oldest_test.sv
